>>> rtl/core/cdht_pkg.sv
package cdht_pkg;

  localparam logic [63:0] GOLDEN_MUL = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_MUL    = 64'hFF51AFD7ED558CCD;
  localparam int unsigned FOLD_SHIFT = 33;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_INSERTED = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    F_IDLE, F_MUL1, F_WAIT1, F_MUL2, F_WAIT2, F_HOLD
  } fstate_t;

  typedef enum logic [2:0] {
    B_CLEAR, B_IDLE, B_RSLOT, B_RENT, B_CMP, B_WRITE, B_OUT
  } bstate_t;

  typedef struct packed {
    logic [7:0]  type_tag;
    logic [63:0] value_bits;
    logic [31:0] hash;
  } job_t;

endpackage

>>> rtl/core/cdht_if.sv
interface cdht_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  type_tag;
  logic [63:0] value_bits;
  modport source (output valid, type_tag, value_bits, input ready);
  modport sink (input valid, type_tag, value_bits, output ready);
endinterface

interface cdht_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [6:0] entry_index;
  modport source (output valid, status, entry_index, input ready);
  modport sink (input valid, status, entry_index, output ready);
endinterface

>>> rtl/core/cdht_mul64.sv
module cdht_mul64
  import cdht_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] prod
);

  // Low 64 bits of a*b from three 32x32 partial products, one per cycle.
  // The product of the two high halves lies entirely above bit 63.
  logic [1:0]  step_r, step_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [63:0] a_r, b_r;
  logic [63:0] acc_r, acc_nxt;
  logic [31:0] opa, opb;
  logic [63:0] pp;

  always_comb begin
    case (step_r)
      2'd0: begin opa = a_r[31:0];  opb = b_r[31:0];  end
      2'd1: begin opa = a_r[63:32]; opb = b_r[31:0];  end
      default: begin opa = a_r[31:0]; opb = b_r[63:32]; end
    endcase
    pp = 64'(opa) * 64'(opb);
    acc_nxt = acc_r;
    if (step_r == 2'd0) acc_nxt = pp;
    else acc_nxt = acc_r + {pp[31:0], 32'd0};
    busy_nxt = busy_r;
    step_nxt = step_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = 2'd0;
    end else if (busy_r) begin
      step_nxt = step_r + 2'd1;
      if (step_r == 2'd2) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end
    if (busy_r) acc_r <= acc_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

>>> rtl/core/cdht_front.sv
module cdht_front
  import cdht_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  cdht_in_if.sink     in_ch,
  output logic        job_valid,
  input  logic        job_ready,
  output job_t        job
);

  fstate_t     st_r, st_nxt;
  logic [7:0]  tag_r;
  logic [63:0] val_r;
  logic [63:0] h_r;
  logic        m_start;
  logic [63:0] m_a, m_b, m_p;
  logic        m_done;
  logic [63:0] h1;

  cdht_mul64 u_mul (
    .clk(clk), .rst_n(rst_n), .start(m_start), .a(m_a), .b(m_b),
    .done(m_done), .prod(m_p)
  );

  assign in_ch.ready = (st_r == F_IDLE);
  assign h1 = (val_r ^ m_p) ^ ((val_r ^ m_p) >> FOLD_SHIFT);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      F_IDLE:  if (in_ch.valid) st_nxt = F_MUL1;
      F_MUL1:  st_nxt = F_WAIT1;
      F_WAIT1: if (m_done) st_nxt = F_MUL2;
      F_MUL2:  st_nxt = F_WAIT2;
      F_WAIT2: if (m_done) st_nxt = F_HOLD;
      F_HOLD:  if (job_ready) st_nxt = F_IDLE;
      default: st_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    m_start = 1'b0;
    m_a = 64'(tag_r);
    m_b = GOLDEN_MUL;
    case (st_r)
      F_MUL1: m_start = 1'b1;
      F_MUL2: begin
        m_start = 1'b1;
        m_a = h_r;
        m_b = MIX_MUL;
      end
      default: m_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_r == F_IDLE && in_ch.valid) begin
      tag_r <= in_ch.type_tag;
      val_r <= in_ch.value_bits;
    end
    if (st_r == F_WAIT1 && m_done) h_r <= h1;
    if (st_r == F_WAIT2 && m_done) h_r <= m_p ^ (m_p >> FOLD_SHIFT);
    if (!rst_n) st_r <= F_IDLE;
    else st_r <= st_nxt;
  end

  assign job_valid = (st_r == F_HOLD);
  assign job.type_tag = tag_r;
  assign job.value_bits = val_r;
  assign job.hash = h_r[31:0];

endmodule

>>> rtl/core/cdht_back.sv
module cdht_back
  import cdht_pkg::*;
#(
  parameter int TABLE_SLOTS = 128,
  parameter int ENTRY_CAP   = 96,
  parameter int SW = $clog2(TABLE_SLOTS),
  parameter int EW = $clog2(ENTRY_CAP + 1)
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_valid,
  output logic        job_ready,
  input  job_t        job,
  cdht_out_if.source  out_ch
);

  localparam int IW = (ENTRY_CAP > 1) ? $clog2(ENTRY_CAP) : 1;

  logic [EW-1:0] slot_mem [TABLE_SLOTS];
  logic [63:0]   val_mem [ENTRY_CAP];
  logic [7:0]    tag_mem [ENTRY_CAP];

  bstate_t       st_r, st_nxt;
  logic [SW-1:0] pos_r, pos_nxt;
  logic [SW:0]   n_r, n_nxt;
  logic [EW-1:0] link_r;
  logic [63:0]   ev_r;
  logic [7:0]    et_r;
  logic [EW-1:0] count_r, count_nxt;
  logic [7:0]    tag_r;
  logic [63:0]   val_r;
  logic [1:0]    ost_r, ost_nxt;
  logic [6:0]    oidx_r, oidx_nxt;
  logic          link_ok;
  logic [EW-1:0] link_m1;

  assign link_m1 = link_r - EW'(1);
  assign link_ok = (link_r != '0) && (link_m1 < EW'(ENTRY_CAP));

  always_comb begin
    st_nxt = st_r;
    pos_nxt = pos_r;
    n_nxt = n_r;
    count_nxt = count_r;
    ost_nxt = ost_r;
    oidx_nxt = oidx_r;
    case (st_r)
      B_CLEAR: begin
        pos_nxt = pos_r + SW'(1);
        if (pos_r == SW'(TABLE_SLOTS - 1)) st_nxt = B_IDLE;
      end
      B_IDLE: if (job_valid) begin
        pos_nxt = job.hash[SW-1:0];
        n_nxt = '0;
        st_nxt = B_RSLOT;
      end
      B_RSLOT: st_nxt = B_RENT;
      B_RENT: begin
        if (link_r == '0) begin
          if (count_r < EW'(ENTRY_CAP)) st_nxt = B_WRITE;
          else begin
            ost_nxt = ST_FULL;
            oidx_nxt = '0;
            st_nxt = B_OUT;
          end
        end else if (link_ok) st_nxt = B_CMP;
        else begin
          pos_nxt = pos_r + SW'(1);
          n_nxt = n_r + (SW+1)'(1);
          st_nxt = B_RSLOT;
          if (n_r == (SW+1)'(TABLE_SLOTS - 1)) begin
            ost_nxt = ST_FULL;
            oidx_nxt = '0;
            st_nxt = B_OUT;
          end
        end
      end
      B_CMP: begin
        if (et_r == tag_r && ev_r == val_r) begin
          ost_nxt = ST_FOUND;
          oidx_nxt = 7'(link_m1);
          st_nxt = B_OUT;
        end else begin
          pos_nxt = pos_r + SW'(1);
          n_nxt = n_r + (SW+1)'(1);
          st_nxt = B_RSLOT;
          if (n_r == (SW+1)'(TABLE_SLOTS - 1)) begin
            ost_nxt = ST_FULL;
            oidx_nxt = '0;
            st_nxt = B_OUT;
          end
        end
      end
      B_WRITE: begin
        ost_nxt = ST_INSERTED;
        oidx_nxt = 7'(count_r);
        count_nxt = count_r + EW'(1);
        st_nxt = B_OUT;
      end
      B_OUT: if (out_ch.ready) st_nxt = B_IDLE;
      default: st_nxt = B_IDLE;
    endcase
  end

  assign job_ready = (st_r == B_IDLE);
  assign out_ch.valid = (st_r == B_OUT);
  assign out_ch.status = ost_r;
  assign out_ch.entry_index = oidx_r;

  always_ff @(posedge clk) begin
    if (st_r == B_CLEAR) slot_mem[pos_r] <= '0;
    if (st_r == B_WRITE) begin
      slot_mem[pos_r] <= count_r + EW'(1);
      val_mem[IW'(count_r)] <= val_r;
      tag_mem[IW'(count_r)] <= tag_r;
    end
    link_r <= slot_mem[pos_r];
    ev_r <= val_mem[IW'(link_m1)];
    et_r <= tag_mem[IW'(link_m1)];
    if (st_r == B_IDLE && job_valid) begin
      tag_r <= job.type_tag;
      val_r <= job.value_bits;
    end
    ost_r <= ost_nxt;
    oidx_r <= oidx_nxt;
    n_r <= n_nxt;
    if (!rst_n) begin
      st_r <= B_CLEAR;
      pos_r <= '0;
      count_r <= '0;
    end else begin
      st_r <= st_nxt;
      pos_r <= pos_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

>>> rtl/core/constant_dedup_hash_table.sv
// Channel | Direction | Payload
// in      | sink      | type_tag[7:0], value_bits[63:0]
// out     | source    | status[1:0], entry_index[6:0]
// The front hashes each item before hand-off from two 64-bit products, each with a
// start step, three 32x32 partial products and a done step.
// It takes a new item only after the back has taken the previous one.
// The back probes each occupied slot in the read-slot, read-entry and compare
// states, the empty slot in the first two, inserts in the write state and holds the
// result until taken. After reset it clears every slot while the front takes and
// hashes one item. A stalled output blocks the back, then the front.
module constant_dedup_hash_table
  import cdht_pkg::*;
#(
  parameter int TABLE_SLOTS = 128,
  parameter int ENTRY_CAP   = 96
)(
  input logic        clk,
  input logic        rst_n,
  cdht_in_if.sink    in_ch,
  cdht_out_if.source out_ch
);

  logic job_valid, job_ready;
  job_t job;

  cdht_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .job_valid(job_valid), .job_ready(job_ready), .job(job)
  );

  cdht_back #(.TABLE_SLOTS(TABLE_SLOTS), .ENTRY_CAP(ENTRY_CAP)) u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job_ready(job_ready),
    .job(job), .out_ch(out_ch)
  );

endmodule

>>> rtl/core/cdht_checker.sv
module cdht_checker
  import cdht_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status,
  input logic [6:0] out_entry_index
);

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_FOUND || out_status == ST_INSERTED ||
                   out_status == ST_FULL))
    else $error("illegal status");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_entry_index == 7'd0)
    else $error("full result with nonzero index");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped while stalled");

endmodule

bind constant_dedup_hash_table cdht_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_status(out_ch.status), .out_entry_index(out_ch.entry_index)
);

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import cdht_pkg::*;

  localparam int SLOTS = 128;
  localparam int CAP = 96;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [7:0]  type_tag;
    logic [63:0] value_bits;
  } const_t;

  typedef struct packed {
    status_t    status;
    logic [6:0] entry_index;
  } lookup_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cdht_in_if in_ch();
  cdht_out_if out_ch();

  constant_dedup_hash_table #(.TABLE_SLOTS(SLOTS), .ENTRY_CAP(CAP)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [6:0]  model_slots [SLOTS];
  logic [63:0] model_values [CAP];
  logic [7:0]  model_types [CAP];
  int unsigned model_count;

  const_t  pending_consts [$];
  lookup_t expected_lookups [$];
  const_t  known_consts [$];
  int      error_count = 0;
  int      idle_cycles = 0;
  bit      send_hold = 1'b0;
  bit      sink_hold = 1'b0;
  bit      sink_hold_done = 1'b0;
  int      burst_left = 0;
  int      gap_left = 0;

  function automatic logic [6:0] hash_slot(logic [7:0] t, logic [63:0] v);
    logic [63:0] h;
    h = v ^ (64'(t) * GOLDEN_MUL);
    h = h ^ (h >> FOLD_SHIFT);
    h = h * MIX_MUL;
    h = h ^ (h >> FOLD_SHIFT);
    return h[6:0];
  endfunction

  function automatic lookup_t intern_const(const_t c);
    lookup_t r;
    int pos;
    bit have_empty;
    int empty_pos;
    int e;
    r.status = ST_FULL;
    r.entry_index = '0;
    pos = hash_slot(c.type_tag, c.value_bits);
    have_empty = 1'b0;
    empty_pos = 0;
    for (int n = 0; n < SLOTS; n++) begin
      if (model_slots[pos] == 0) begin
        have_empty = 1'b1;
        empty_pos = pos;
        break;
      end
      e = model_slots[pos] - 1;
      if (e < CAP && model_types[e] == c.type_tag && model_values[e] == c.value_bits) begin
        r.status = ST_FOUND;
        r.entry_index = 7'(e);
        break;
      end
      pos = (pos + 1) % SLOTS;
    end
    if (r.status != ST_FOUND && have_empty && model_count < CAP) begin
      r.entry_index = 7'(model_count);
      model_values[model_count] = c.value_bits;
      model_types[model_count] = c.type_tag;
      model_slots[empty_pos] = 7'(model_count + 1);
      model_count++;
      r.status = ST_INSERTED;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  task automatic queue_const(logic [7:0] t, logic [63:0] v);
    const_t c;
    c.type_tag = t;
    c.value_bits = v;
    pending_consts.push_back(c);
    known_consts.push_back(c);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Driver: bursts and gaps, held off when a drain pause is requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.type_tag <= '0;
      in_ch.value_bits <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_lookups.push_back(intern_const({in_ch.type_tag, in_ch.value_bits}));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (!send_hold && pending_consts.size() > 0) begin
          const_t c;
          c = pending_consts.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.type_tag <= c.type_tag;
          in_ch.value_bits <= c.value_bits;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver stall pattern.
  int stall_phase = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_lookups.size() == 0) begin
          report_mismatch("unexpected transaction", out_ch.status, -1);
        end else begin
          lookup_t w;
          w = expected_lookups.pop_front();
          if (out_ch.status !== w.status) report_mismatch("status", out_ch.status, w.status);
          if (out_ch.entry_index !== w.entry_index)
            report_mismatch("entry_index", out_ch.entry_index, w.entry_index);
        end
      end
      stall_phase = (stall_phase + 1) % 64;
      if (sink_hold) out_ch.ready <= 1'b0;
      else if (stall_phase < 20) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(0, 2) != 0);
    end
  end

  // Long receiver hold while the sender keeps offering items.
  initial begin
    wait (rst_n);
    repeat (200) @(posedge clk);
    sink_hold = 1'b1;
    repeat (400) @(posedge clk);
    sink_hold = 1'b0;
    sink_hold_done = 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired");
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) model_slots[i] = '0;
    for (int i = 0; i < CAP; i++) begin
      model_values[i] = '0;
      model_types[i] = '0;
    end
    model_count = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    queue_const(8'h00, 64'h0);
    queue_const(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_const(8'h00, 64'h0);
    queue_const(8'hFF, 64'h0);
    queue_const(8'h00, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_const(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_const(8'h01, 64'h8000_0000_0000_0000);
    queue_const(8'h80, 64'h1);
    queue_const(8'h00, 64'h0);
    queue_const(8'h55, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_const(8'hAA, 64'h5555_5555_5555_5555);
    for (int i = 0; i < 40; i++) queue_const(8'($urandom), rand64());

    // Random mix: repeats of known constants, near values, and fresh ones.
    // Capacity is soon reached, after which fresh misses report full.
    for (int i = 0; i < 900; i++) begin
      int k;
      k = $urandom_range(0, 9);
      if (k < 5) begin
        const_t c;
        c = known_consts[$urandom_range(0, known_consts.size() - 1)];
        if (k == 4) c.type_tag = c.type_tag ^ (8'h1 << $urandom_range(0, 7));
        queue_const(c.type_tag, c.value_bits);
      end else if (k < 7) begin
        queue_const(8'($urandom_range(0, 3)), 64'($urandom_range(0, 15)));
      end else begin
        queue_const(8'($urandom), rand64());
      end
      if (i == 450) begin
        // Pause the sender until every result has come back.
        wait (sink_hold_done);
        send_hold = 1'b1;
        repeat (2) @(posedge clk);
        while (in_ch.valid || expected_lookups.size() > 0) @(posedge clk);
        send_hold = 1'b0;
      end
    end

    while (pending_consts.size() > 0 || in_ch.valid) @(posedge clk);
    while (expected_lookups.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
